// File: rtl/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared widths, constants and types of the IR pulse-length receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ipr_pkg;

  localparam int unsigned RelDivisorDef = 4;
  localparam int unsigned ChannelsDef   = 4;
  localparam int unsigned NumSamples    = 4;

  localparam int unsigned SampleW = 10;
  localparam int unsigned WordW   = 6;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ChW     = 2;

  localparam logic [CntW-1:0]    WordDone     = 3'd7;
  localparam logic [SampleW-1:0] MinRiseReset = 10'd20;

  typedef struct packed {
    logic               done;
    logic [WordW-1:0]   data;
    logic [SampleW-1:0] strength;
  } chan_res_t;

endpackage

`default_nettype wire

// File: rtl/ipr_smp_if.sv
// ----------------------------------------------------------------------------
// ipr_smp_if
// Sample channel: one word carries one sample of each of the four sensors.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_smp_if;
  logic                         valid;
  logic                         ready;
  logic [ipr_pkg::SampleW-1:0]  sample_a;
  logic [ipr_pkg::SampleW-1:0]  sample_b;
  logic [ipr_pkg::SampleW-1:0]  sample_c;
  logic [ipr_pkg::SampleW-1:0]  sample_d;

  modport source (output valid, output sample_a, output sample_b,
                  output sample_c, output sample_d, input ready);
  modport sink   (input valid, input sample_a, input sample_b,
                  input sample_c, input sample_d, output ready);
endinterface

`default_nettype wire

// File: rtl/ipr_res_if.sv
// ----------------------------------------------------------------------------
// ipr_res_if
// Result channel: one word per completed received word of one sensor.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_res_if;
  logic                         valid;
  logic                         ready;
  logic [ipr_pkg::ChW-1:0]      channel;
  logic [ipr_pkg::WordW-1:0]    data_word;
  logic [ipr_pkg::SampleW-1:0]  strength;
  logic                         final_flag;

  modport source (output valid, output channel, output data_word,
                  output strength, output final_flag, input ready);
  modport sink   (input valid, input channel, input data_word,
                  input strength, input final_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/ipr_cfg_if.sv
// ----------------------------------------------------------------------------
// ipr_cfg_if
// Configuration write channel for the min_rise register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ipr_pkg::SampleW-1:0]  min_rise;

  modport source (output valid, output min_rise, input ready);
  modport sink   (input valid, input min_rise, output ready);
endinterface

`default_nettype wire

// File: rtl/ipr_chan.sv
// ----------------------------------------------------------------------------
// ipr_chan
// One sensor channel: baseline, high detection and pulse-length bit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_chan #(
  parameter int unsigned REL_DIVISOR = ipr_pkg::RelDivisorDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [ipr_pkg::SampleW-1:0] sample_i,
  input  wire logic [ipr_pkg::SampleW-1:0] min_rise_i,
  output ipr_pkg::chan_res_t               res_o
);

  localparam int unsigned SW = ipr_pkg::SampleW;
  localparam int unsigned WW = ipr_pkg::WordW;
  localparam int unsigned CW = ipr_pkg::CntW;

  // base / REL_DIVISOR as a multiply by a rounded-up reciprocal, exact for SW-bit base
  localparam int unsigned RecipSh  = 20;
  localparam int unsigned RecipMul = ((1 << RecipSh) + REL_DIVISOR - 1) / REL_DIVISOR;
  localparam int unsigned PW       = SW + RecipSh + 1;

  logic [SW-1:0] prev_q, prev_d;
  logic [SW-1:0] older_q, older_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [WW-1:0] word_q, word_d;

  logic [SW-1:0] base;
  logic [PW-1:0] rel_prod;
  logic [SW-1:0] base_rel;
  logic          high_cur, high_prev, high_older;
  logic [CW-1:0] cnt_adv;

  function automatic logic is_high(input logic [SW-1:0] x, input logic [SW-1:0] b,
                                   input logic [SW-1:0] rel, input logic [SW-1:0] rise);
    logic [SW:0] lim_rel;
    logic [SW:0] lim_abs;
    lim_rel = {1'b0, b} + {1'b0, rel};
    lim_abs = {1'b0, b} + {1'b0, rise};
    return ({1'b0, x} > lim_rel) && ({1'b0, x} > lim_abs);
  endfunction

  always_comb begin
    base = prev_q;
    if (older_q < base) begin
      base = older_q;
    end
    if (sample_i < base) begin
      base = sample_i;
    end
    rel_prod   = PW'(base) * PW'(RecipMul);
    base_rel   = SW'(rel_prod >> RecipSh);
    high_cur   = is_high(sample_i, base, base_rel, min_rise_i);
    high_prev  = is_high(prev_q, base, base_rel, min_rise_i);
    high_older = is_high(older_q, base, base_rel, min_rise_i);

    cnt_d  = cnt_q;
    word_d = word_q;
    if (high_cur) begin
      if (cnt_q == '0) begin
        cnt_d  = CW'(1);
        word_d = '0;
      end
    end else if (high_prev) begin
      if (high_older && (cnt_q != '0)) begin
        word_d = word_q | WW'(1 << (cnt_q - CW'(1)));
      end
      cnt_d = cnt_q + CW'(1);
    end else begin
      cnt_d = '0;
    end

    res_o.done     = (cnt_d == ipr_pkg::WordDone);
    res_o.data     = word_d;
    res_o.strength = prev_q - base;
    cnt_adv        = res_o.done ? '0 : cnt_d;
    older_d        = prev_q;
    prev_d         = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      older_q <= '0;
      cnt_q   <= '0;
      word_q  <= '0;
    end else if (en_i) begin
      prev_q  <= prev_d;
      older_q <= older_d;
      cnt_q   <= cnt_adv;
      word_q  <= word_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ir_pulse_length_receiver.sv
// ----------------------------------------------------------------------------
// ir_pulse_length_receiver
// Four-channel infrared pulse-length word receiver.
// Data path: a tick's completed words pass through the pending register, then
//   the result register.
// Throughput: one tick per cycle while each tick completes at most one word and
//   res_o does not stall; a tick completing more words holds the input while the
//   single result register takes its pending words one per cycle when it is free.
// Reset: channel state cleared, min_rise = 20, no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_length_receiver #(
  parameter int unsigned REL_DIVISOR = ipr_pkg::RelDivisorDef,
  parameter int unsigned CHANNELS    = ipr_pkg::ChannelsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ipr_cfg_if.sink   cfg_i,
  ipr_smp_if.sink   smp_i,
  ipr_res_if.source res_o
);

  localparam int unsigned NCH = (CHANNELS < ipr_pkg::NumSamples) ?
                                CHANNELS : ipr_pkg::NumSamples;
  localparam int unsigned SW  = ipr_pkg::SampleW;
  localparam int unsigned WW  = ipr_pkg::WordW;
  localparam int unsigned CHW = ipr_pkg::ChW;

  logic [SW-1:0] min_rise_q;
  logic [SW-1:0] smp [ipr_pkg::NumSamples];

  ipr_pkg::chan_res_t ch_res [NCH];
  logic [NCH-1:0]     done;

  // per-tick pending results
  logic [NCH-1:0] mask_q, mask_d;
  logic [WW-1:0]  pend_data_q [NCH];
  logic [SW-1:0]  pend_str_q  [NCH];

  logic [NCH-1:0] sel_oh;
  logic [NCH-1:0] rem;
  logic [CHW-1:0] sel_ch;
  logic [WW-1:0]  sel_data;
  logic [SW-1:0]  sel_str;
  logic           out_free, move, in_acc;

  logic           out_valid_q;
  logic [CHW-1:0] out_ch_q;
  logic [WW-1:0]  out_data_q;
  logic [SW-1:0]  out_str_q;
  logic           out_final_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rise_q <= ipr_pkg::MinRiseReset;
    end else if (cfg_i.valid) begin
      min_rise_q <= cfg_i.min_rise;
    end
  end

  assign smp[0] = smp_i.sample_a;
  assign smp[1] = smp_i.sample_b;
  assign smp[2] = smp_i.sample_c;
  assign smp[3] = smp_i.sample_d;

  for (genvar g = 0; g < NCH; g++) begin : g_chan
    ipr_chan #(
      .REL_DIVISOR(REL_DIVISOR)
    ) u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (in_acc),
      .sample_i  (smp[g]),
      .min_rise_i(min_rise_q),
      .res_o     (ch_res[g])
    );
    assign done[g] = ch_res[g].done;
  end

  // lowest pending channel goes out first
  always_comb begin
    sel_oh   = '0;
    sel_ch   = '0;
    sel_data = '0;
    sel_str  = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_oh   = NCH'(1) << i;
        sel_ch   = CHW'(i);
        sel_data = pend_data_q[i];
        sel_str  = pend_str_q[i];
      end
    end
  end

  assign out_free    = !out_valid_q || res_o.ready;
  assign move        = (mask_q != '0) && out_free;
  assign rem         = mask_q & ~(move ? sel_oh : '0);
  assign smp_i.ready = (rem == '0);
  assign in_acc      = smp_i.valid && smp_i.ready;
  assign mask_d      = in_acc ? done : rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < NCH; i++) begin
        pend_data_q[i] <= ch_res[i].data;
        pend_str_q[i]  <= ch_res[i].strength;
      end
    end
    if (move) begin
      out_ch_q    <= sel_ch;
      out_data_q  <= sel_data;
      out_str_q   <= sel_str;
      out_final_q <= ((mask_q & ~sel_oh) == '0);
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.channel    = out_ch_q;
  assign res_o.data_word  = out_data_q;
  assign res_o.strength   = out_str_q;
  assign res_o.final_flag = out_final_q;

  a_load_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (done != '0)) |=> (mask_q != '0))
    else $error("completed words not queued");

  a_move_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("result register not loaded");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (out_final_q == ($past(mask_q & ~sel_oh) == '0)))
    else $error("final flag mismatch");

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the IR pulse-length receiver. Each sensor
// channel gets its own stream of baseline levels and one- or two-tick pulses
// that spell 6-bit words, mixed with noise and broken pulse trains. A
// cycle-accurate predictor tracks the channel state and queues the words it
// expects, and a monitor compares every result word in order. Both
// handshakes idle at random, and min_rise is swept across its range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipr_pkg::*;

  typedef logic [NumSamples-1:0][SampleW-1:0] tick_t;

  typedef struct packed {
    logic [ChW-1:0]     channel;
    logic [WordW-1:0]   data_word;
    logic [SampleW-1:0] strength;
    logic               final_flag;
  } rx_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ipr_cfg_if cfg_bus ();
  ipr_smp_if smp_bus ();
  ipr_res_if res_bus ();

  ir_pulse_length_receiver DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .smp_i (smp_bus),
    .res_o (res_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver model state
  logic [SampleW-1:0] min_rise_q = MinRiseReset;
  logic [SampleW-1:0] last_smp  [NumSamples] = '{default: '0};
  logic [SampleW-1:0] older_smp [NumSamples] = '{default: '0};
  logic [CntW-1:0]    bit_cnt   [NumSamples] = '{default: '0};
  logic [WordW-1:0]   word_acc  [NumSamples] = '{default: '0};

  rx_word_t        rx_word_q [$];
  tick_t           tick_q [$];
  logic [SampleW-1:0] stream [NumSamples][$];

  tick_t held_tick;
  int    gap_left, burst_left, stall_left, steady_left;
  int    ticks_sent, multi_ticks, words_checked, err_cnt, settings_cnt;

  function automatic bit is_high(input int x, input int base);
    return (x > base + base / int'(RelDivisorDef)) && (x > base + int'(min_rise_q));
  endfunction

  task automatic decode_tick(input tick_t t);
    int cur, p, o, base, n;
    rx_word_t w;
    n = 0;
    for (int c = 0; c < NumSamples; c++) begin
      cur  = t[c];
      p    = last_smp[c];
      o    = older_smp[c];
      base = p;
      if (o < base) base = o;
      if (cur < base) base = cur;
      if (is_high(cur, base)) begin
        if (bit_cnt[c] == 0) begin
          bit_cnt[c]  = 1;
          word_acc[c] = '0;
        end
      end else if (is_high(p, base)) begin
        if (is_high(o, base) && bit_cnt[c] != 0) word_acc[c][bit_cnt[c] - 1] = 1'b1;
        bit_cnt[c] = bit_cnt[c] + 1'b1;
      end else begin
        bit_cnt[c] = '0;
      end
      if (bit_cnt[c] == WordDone) begin
        bit_cnt[c]   = '0;
        w.channel    = ChW'(c);
        w.data_word  = word_acc[c];
        w.strength   = SampleW'(p - base);
        w.final_flag = 1'b0;
        rx_word_q.push_back(w);
        n++;
      end
      older_smp[c] = SampleW'(p);
      last_smp[c]  = SampleW'(cur);
    end
    if (n > 0) rx_word_q[rx_word_q.size() - 1].final_flag = 1'b1;
    if (n > 1) multi_ticks++;
    ticks_sent++;
  endtask

  // ---- stimulus generation ----

  function automatic int noise_sample();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 1023 : 0;
    return $urandom_range(0, 1023);
  endfunction

  // h > 0: fixed level, h == 0: just over threshold, h < 0: random
  function automatic int high_level(input int hmin, input int h);
    if (h > 0) return h;
    if (h == 0 || $urandom_range(0, 3) == 0) return hmin;
    return $urandom_range(hmin, 1023);
  endfunction

  function automatic void append_word(input int c, input int lvl, input logic [5:0] pat,
                                      input int h, input bit rough);
    int hmin, len, rise;
    rise = int'(min_rise_q);
    hmin = lvl + ((lvl / int'(RelDivisorDef) > rise) ? lvl / int'(RelDivisorDef) : rise) + 1;
    stream[c].push_back(SampleW'(lvl));
    stream[c].push_back(SampleW'(lvl));
    for (int i = 0; i < WordW; i++) begin
      len = pat[i] ? 2 : 1;
      if (rough && $urandom_range(0, 5) == 0) len = 3;
      for (int k = 0; k < len; k++) stream[c].push_back(SampleW'(high_level(hmin, h)));
      stream[c].push_back(SampleW'(lvl));
      if (rough && $urandom_range(0, 7) == 0) stream[c].push_back(SampleW'(lvl));
    end
  endfunction

  function automatic void append_segment(input int c);
    int lvl_max, lvl, r;
    logic [5:0] pat;
    lvl_max = 1022 - int'(min_rise_q);
    if (lvl_max > 817) lvl_max = 817;
    r = $urandom_range(0, 99);
    if (lvl_max < 0 || r < 12) begin
      repeat ($urandom_range(1, 6)) stream[c].push_back(SampleW'(noise_sample()));
    end else begin
      lvl = $urandom_range(0, lvl_max);
      case ($urandom_range(0, 7))
        0:       pat = '1;
        1:       pat = '0;
        default: pat = WordW'($urandom);
      endcase
      append_word(c, lvl, pat, -1, r < 30);
      // sudden drop right after a word: old bits survive into the next count
      if ($urandom_range(0, 4) == 0 && lvl > int'(min_rise_q)) stream[c].push_back('0);
    end
  endfunction

  function automatic void queue_ticks(input int count);
    tick_t t;
    for (int i = 0; i < count; i++) begin
      for (int c = 0; c < NumSamples; c++)
        t[c] = (stream[c].size() != 0) ? stream[c].pop_front() : SampleW'(noise_sample());
      tick_q.push_back(t);
    end
    for (int c = 0; c < NumSamples; c++) stream[c].delete();
  endfunction

  function automatic void queue_random(input int count);
    for (int c = 0; c < NumSamples; c++)
      while (stream[c].size() < count) append_segment(c);
    queue_ticks(count);
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || smp_bus.valid || rx_word_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_rise(input logic [SampleW-1:0] v);
    cfg_bus.min_rise <= v;
    cfg_bus.valid    <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    min_rise_q = v;
    cfg_bus.valid <= 1'b0;
    settings_cnt++;
  endtask

  // ---- sample word driver ----

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(15, 40);
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_bus.valid    <= 1'b0;
      smp_bus.sample_a <= '0;
      smp_bus.sample_b <= '0;
      smp_bus.sample_c <= '0;
      smp_bus.sample_d <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (smp_bus.valid && smp_bus.ready) decode_tick(held_tick);
      if (!smp_bus.valid || smp_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          smp_bus.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          held_tick = tick_q.pop_front();
          smp_bus.sample_a <= held_tick[0];
          smp_bus.sample_b <= held_tick[1];
          smp_bus.sample_c <= held_tick[2];
          smp_bus.sample_d <= held_tick[3];
          smp_bus.valid    <= 1'b1;
          gap_left = next_gap();
        end else begin
          smp_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---- result word monitor ----

  task automatic check_word();
    rx_word_t got, want;
    got = '{res_bus.channel, res_bus.data_word, res_bus.strength, res_bus.final_flag};
    if (rx_word_q.size() == 0) begin
      if (err_cnt < 10)
        $display("ERROR %0t: unexpected word ch=%0d data=%h strength=%0d final=%0b",
                 $realtime, got.channel, got.data_word, got.strength, got.final_flag);
      err_cnt++;
    end else begin
      want = rx_word_q.pop_front();
      if (got !== want) begin
        if (err_cnt < 10)
          $display({"ERROR %0t: ch=%0d data=%h strength=%0d final=%0b, ",
                    "expected ch=%0d data=%h strength=%0d final=%0b"}, $realtime,
                   got.channel, got.data_word, got.strength, got.final_flag,
                   want.channel, want.data_word, want.strength, want.final_flag);
        err_cnt++;
      end
    end
    words_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left  = 0;
      steady_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) check_word();
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else if ($urandom_range(0, 39) == 0) begin
          steady_left = $urandom_range(20, 60);
        end else if ($urandom_range(0, 99) < 15) begin
          case ($urandom_range(0, 9))
            0:       stall_left = $urandom_range(10, 40);
            1, 2:    stall_left = $urandom_range(3, 6);
            default: stall_left = $urandom_range(1, 2);
          endcase
        end
      end
    end
  end

  // ---- sequence ----

  initial begin
    cfg_bus.valid    = 1'b0;
    cfg_bus.min_rise = '0;
    smp_bus.valid    = 1'b0;
    smp_bus.sample_a = '0;
    smp_bus.sample_b = '0;
    smp_bus.sample_c = '0;
    smp_bus.sample_d = '0;
    res_bus.ready    = 1'b0;
    settings_cnt = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // same total pulse length on all channels so four words finish on one tick
    append_word(0, 300, 6'b101101, -1, 1'b0);
    append_word(1, 0,   6'b111100, 1023, 1'b0);
    append_word(2, 817, 6'b001111, 0, 1'b0);
    append_word(3, 40,  6'b110011, 0, 1'b0);
    stream[0].push_back('0);
    stream[1].push_back('0);
    stream[2].push_back(10'd817);
    stream[3].push_back(10'd40);
    for (int c = 0; c < NumSamples; c++) begin
      stream[c].push_back(10'd1023);
      stream[c].push_back('0);
    end
    queue_ticks(stream[0].size());
    queue_random(90);

    wait_idle();
    write_min_rise('0);
    queue_random(30);
    wait_idle();
    queue_random(30);

    wait_idle();
    write_min_rise(10'd1023);
    queue_random(20);

    wait_idle();
    write_min_rise(10'd1022);
    queue_random(40);

    wait_idle();
    write_min_rise(SampleW'($urandom_range(21, 300)));
    queue_random(60);

    wait_idle();
    write_min_rise(10'd1);
    queue_random(60);

    wait_idle();
    $display("covered %0d sample ticks over %0d min_rise settings, %0d of them ending words on several channels",
             ticks_sent, settings_cnt, multi_ticks);
    $display("checked %0d result words, %0d mismatches, %0d words missing",
             words_checked, err_cnt, rx_word_q.size());
    if (err_cnt == 0 && rx_word_q.size() == 0) begin
      $display("ir_pulse_length_receiver regression: pass");
    end else begin
      $display("ir_pulse_length_receiver regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d ticks queued and %0d words expected",
             tick_q.size(), rx_word_q.size());
    $display("ir_pulse_length_receiver regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
